// ===== src/mrp_pkg.sv =====
package mrp_pkg;

    localparam int KEY_BYTES = 32;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [9:0] MIN_RECORD_RESET = 10'd64;
    localparam logic [7:0] VERSION_RESET    = 8'h01;

    // Register indexes, taken from paddr[2].
    localparam logic REG_MIN_RECORD = 1'b0;
    localparam logic REG_VERSION    = 1'b1;

    // Field codes, which double as the parser phase.
    localparam logic [3:0] PH_VERSION = 4'd0;
    localparam logic [3:0] PH_TYPELEN = 4'd1;
    localparam logic [3:0] PH_TYPE    = 4'd2;
    localparam logic [3:0] PH_TIME    = 4'd3;
    localparam logic [3:0] PH_NONCE   = 4'd4;
    localparam logic [3:0] PH_KEY     = 4'd5;
    localparam logic [3:0] PH_IVLEN   = 4'd6;
    localparam logic [3:0] PH_IV      = 4'd7;
    localparam logic [3:0] PH_TAGLEN  = 4'd8;
    localparam logic [3:0] PH_TAG     = 4'd9;
    localparam logic [3:0] PH_SIGLEN  = 4'd10;
    localparam logic [3:0] PH_SIG     = 4'd11;
    localparam logic [3:0] PH_PAYLEN  = 4'd12;
    localparam logic [3:0] PH_PAYLOAD = 4'd13;
    localparam logic [3:0] PH_DISCARD = 4'd14;

    localparam logic [3:0] ST_OK      = 4'd0;
    localparam logic [3:0] ST_SHORT   = 4'd1;
    localparam logic [3:0] ST_VERSION = 4'd2;
    localparam logic [3:0] ST_TYPE    = 4'd3;
    localparam logic [3:0] ST_HEADER  = 4'd4;
    localparam logic [3:0] ST_KEY     = 4'd5;
    localparam logic [3:0] ST_IV      = 4'd6;
    localparam logic [3:0] ST_TAG     = 4'd7;
    localparam logic [3:0] ST_SIG     = 4'd8;
    localparam logic [3:0] ST_PAYLOAD = 4'd9;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       too_short;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef struct packed {
        logic [3:0]  field_code;
        logic [7:0]  byte_out;
        logic [63:0] word_value;
        logic        word_valid;
        logic        record_end;
        logic [3:0]  status;
    } t_result;

    // Byte count of a number phase, zero for a data phase.
    function automatic logic [3:0] number_width(input logic [3:0] ph);
        logic [3:0] w;
        unique case (ph)
            PH_TYPELEN, PH_IVLEN, PH_TAGLEN, PH_SIGLEN: w = 4'd2;
            PH_TIME, PH_NONCE:                          w = 4'd8;
            PH_PAYLEN:                                  w = 4'd4;
            default:                                    w = 4'd0;
        endcase
        return w;
    endfunction

    // Status of a record that ends while a phase is still open.
    function automatic logic [3:0] end_status(input logic [3:0] ph);
        logic [3:0] s;
        unique case (ph)
            PH_TYPE:    s = ST_TYPE;
            PH_KEY:     s = ST_KEY;
            PH_IV:      s = ST_IV;
            PH_TAG:     s = ST_TAG;
            PH_SIG:     s = ST_SIG;
            PH_PAYLOAD: s = ST_PAYLOAD;
            PH_DISCARD: s = ST_OK;
            default:    s = ST_HEADER;
        endcase
        return s;
    endfunction

endpackage

// ===== src/mrp_in_if.sv =====
interface mrp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== src/mrp_out_if.sv =====
interface mrp_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  field_code;
    logic [7:0]  byte_out;
    logic [63:0] word_value;
    logic        word_valid;
    logic        record_end;
    logic [3:0]  status;

    modport source (
        output valid, output field_code, output byte_out, output word_value,
        output word_valid, output record_end, output status, input ready
    );
    modport sink (
        input valid, input field_code, input byte_out, input word_value,
        input word_valid, input record_end, input status, output ready
    );
endinterface

// ===== src/mrp_front.sv =====
module mrp_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    mrp_in_if.sink                 i_in,
    input  logic [9:0]             i_min_record_bytes,
    input  mrp_pkg::t_queue_status i_queue_status,
    output logic                   o_push,
    output mrp_pkg::t_entry        o_entry
);

    logic [9:0] r_record_count;
    logic [9:0] n_record_count;
    logic [9:0] count_inc;

    assign i_in.ready = !i_queue_status.full;
    assign o_push     = i_in.valid && i_in.ready;

    // Byte count saturates at its maximum so very long records never wrap to short.
    assign count_inc = (r_record_count == 10'h3FF) ? r_record_count : r_record_count + 10'd1;

    assign o_entry.data_byte = i_in.data_byte;
    assign o_entry.last_byte = i_in.last_byte;
    assign o_entry.too_short = (count_inc < i_min_record_bytes);

    always_comb begin
        n_record_count = r_record_count;
        if (o_push) begin
            n_record_count = i_in.last_byte ? 10'd0 : count_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_record_count <= 10'd0;
        end else begin
            r_record_count <= n_record_count;
        end
    end

endmodule

// ===== src/mrp_queue.sv =====
module mrp_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  mrp_pkg::t_entry        i_entry,
    input  logic                   i_pop,
    output mrp_pkg::t_entry        o_head,
    output mrp_pkg::t_queue_status o_status
);

    mrp_pkg::t_entry r_mem [mrp_pkg::QUEUE_DEPTH];

    logic [mrp_pkg::QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [mrp_pkg::QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [mrp_pkg::QUEUE_CNT_W-1:0] r_count;
    logic [mrp_pkg::QUEUE_PTR_W-1:0] n_wr_ptr;
    logic [mrp_pkg::QUEUE_PTR_W-1:0] n_rd_ptr;
    logic [mrp_pkg::QUEUE_CNT_W-1:0] n_count;

    localparam logic [mrp_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
        mrp_pkg::QUEUE_PTR_W'(mrp_pkg::QUEUE_DEPTH - 1);
    localparam logic [mrp_pkg::QUEUE_CNT_W-1:0] FULL_COUNT =
        mrp_pkg::QUEUE_CNT_W'(mrp_pkg::QUEUE_DEPTH);

    assign o_status.full  = (r_count == FULL_COUNT);
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// ===== src/mrp_back.sv =====
module mrp_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [7:0]             i_expected_version,
    input  mrp_pkg::t_entry        i_head,
    input  mrp_pkg::t_queue_status i_queue_status,
    output logic                   o_pop,
    mrp_out_if.source              o_out
);

    logic [3:0]  r_phase;
    logic [31:0] r_bytes_left;
    logic [2:0]  r_byte_in_field;
    logic [63:0] r_word;
    logic [3:0]  r_error;
    logic [3:0]  n_phase;
    logic [31:0] n_bytes_left;
    logic [2:0]  n_byte_in_field;
    logic [63:0] n_word;
    logic [3:0]  n_error;

    logic             r_out_valid;
    mrp_pkg::t_result r_out;
    mrp_pkg::t_result n_out;

    logic [3:0]  width;
    logic [63:0] acc_word;
    logic [31:0] left_dec;
    logic [63:0] field_len;

    // The output register frees up in the same cycle its beat is taken.
    assign o_pop = !i_queue_status.empty && (!r_out_valid || o_out.ready);

    assign width     = mrp_pkg::number_width(r_phase);
    assign acc_word  = r_word | ({56'd0, i_head.data_byte} << {r_byte_in_field, 3'b000});
    assign left_dec  = (r_bytes_left != 32'd0) ? r_bytes_left - 32'd1 : 32'd0;
    assign field_len = (r_phase == mrp_pkg::PH_NONCE) ? 64'(mrp_pkg::KEY_BYTES) : acc_word;

    always_comb begin
        n_phase         = r_phase;
        n_bytes_left    = r_bytes_left;
        n_byte_in_field = r_byte_in_field;
        n_word          = r_word;
        n_error         = r_error;
        n_out.field_code = mrp_pkg::PH_DISCARD;
        n_out.byte_out   = i_head.data_byte;
        n_out.word_value = 64'd0;
        n_out.word_valid = 1'b0;
        n_out.record_end = i_head.last_byte;
        n_out.status     = mrp_pkg::ST_OK;

        if (r_error == mrp_pkg::ST_OK) begin
            n_out.field_code = r_phase;
            priority if (r_phase == mrp_pkg::PH_VERSION) begin
                if (i_head.data_byte != i_expected_version) begin
                    n_error = mrp_pkg::ST_VERSION;
                    n_phase = mrp_pkg::PH_DISCARD;
                end else begin
                    n_phase         = mrp_pkg::PH_TYPELEN;
                    n_byte_in_field = 3'd0;
                    n_word          = 64'd0;
                end
            end else if (r_phase == mrp_pkg::PH_DISCARD) begin
                // A byte beyond the payload.
                n_error = mrp_pkg::ST_PAYLOAD;
            end else if (width != 4'd0) begin
                if (({1'b0, r_byte_in_field} + 4'd1) >= width) begin
                    n_out.word_value = acc_word;
                    n_out.word_valid = 1'b1;
                    n_word           = 64'd0;
                    n_byte_in_field  = 3'd0;
                    if (r_phase == mrp_pkg::PH_TIME) begin
                        n_phase = mrp_pkg::PH_NONCE;
                    end else if (field_len == 64'd0) begin
                        // An empty data field is skipped.
                        n_phase = r_phase + 4'd2;
                    end else begin
                        n_phase      = r_phase + 4'd1;
                        n_bytes_left = field_len[31:0];
                    end
                end else begin
                    n_word          = acc_word;
                    n_byte_in_field = r_byte_in_field + 3'd1;
                end
            end else begin
                n_bytes_left = left_dec;
                if (left_dec == 32'd0) begin
                    n_phase = r_phase + 4'd1;
                end
            end
        end

        if (i_head.last_byte) begin
            priority if (i_head.too_short) begin
                n_out.status = mrp_pkg::ST_SHORT;
            end else if (n_error != mrp_pkg::ST_OK) begin
                n_out.status = n_error;
            end else begin
                n_out.status = mrp_pkg::end_status(n_phase);
            end
            n_phase         = mrp_pkg::PH_VERSION;
            n_bytes_left    = 32'd0;
            n_byte_in_field = 3'd0;
            n_word          = 64'd0;
            n_error         = mrp_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= mrp_pkg::PH_VERSION;
            r_bytes_left    <= 32'd0;
            r_byte_in_field <= 3'd0;
            r_word          <= 64'd0;
            r_error         <= mrp_pkg::ST_OK;
            r_out_valid     <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase         <= n_phase;
                r_bytes_left    <= n_bytes_left;
                r_byte_in_field <= n_byte_in_field;
                r_word          <= n_word;
                r_error         <= n_error;
                r_out_valid     <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.field_code = r_out.field_code;
    assign o_out.byte_out   = r_out.byte_out;
    assign o_out.word_value = r_out.word_value;
    assign o_out.word_valid = r_out.word_valid;
    assign o_out.record_end = r_out.record_end;
    assign o_out.status     = r_out.status;

endmodule

// ===== src/message_record_parser_core.sv =====
// Channel  Direction  Beat content
// i_in     in         data_byte[7:0], last_byte
// o_out    out        field_code[3:0], byte_out[7:0], word_value[63:0], word_valid,
//                     record_end, status[3:0]
// APB      in/out     min_record_bytes at 0x0, expected_version at 0x4
//
// One beat in and one beat out per cycle while neither side stalls; an accepted byte
// passes through the queue and then the output register before it is offered.
// The input side counts record bytes, the four-entry queue decouples it from the parser
// state machine, which handles one byte per cycle into the output register unless stalled.
// i_in.ready drops only while the queue is full.
// Synchronous reset clears the parser, queue and registers to their defaults.
module message_record_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mrp_in_if.sink      i_in,
    mrp_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [9:0] r_min_record_bytes;
    logic [7:0] r_expected_version;
    logic       cfg_write;

    logic                   push;
    logic                   pop;
    mrp_pkg::t_entry        entry;
    mrp_pkg::t_entry        head;
    mrp_pkg::t_queue_status queue_status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_record_bytes <= mrp_pkg::MIN_RECORD_RESET;
            r_expected_version <= mrp_pkg::VERSION_RESET;
        end else if (cfg_write) begin
            unique case (paddr[2])
                mrp_pkg::REG_MIN_RECORD: r_min_record_bytes <= pwdata[9:0];
                mrp_pkg::REG_VERSION:    r_expected_version <= pwdata[7:0];
                default:                 ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            mrp_pkg::REG_MIN_RECORD: prdata = {22'd0, r_min_record_bytes};
            mrp_pkg::REG_VERSION:    prdata = {24'd0, r_expected_version};
            default:                 prdata = 32'd0;
        endcase
    end

    mrp_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in               (i_in),
        .i_min_record_bytes (r_min_record_bytes),
        .i_queue_status     (queue_status),
        .o_push             (push),
        .o_entry            (entry)
    );

    mrp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (entry),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (queue_status)
    );

    mrp_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_expected_version (r_expected_version),
        .i_head             (head),
        .i_queue_status     (queue_status),
        .o_pop              (pop),
        .o_out              (o_out)
    );

endmodule

// ===== src/mrp_checker.sv =====
module mrp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [3:0]  i_field_code,
    input logic [63:0] i_word_value,
    input logic        i_word_valid,
    input logic        i_record_end,
    input logic [3:0]  i_status
);

    // A stalled output beat stays offered.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("output beat dropped while stalled");

    a_word_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_word_valid |-> i_word_value == 64'd0)
        else $error("word value nonzero without word valid");

    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_record_end |-> i_status == mrp_pkg::ST_OK)
        else $error("status given before record end");

    // Completed numbers only come from length, timestamp or nonce fields.
    a_word_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_word_valid |->
            (i_field_code == mrp_pkg::PH_TYPELEN || i_field_code == mrp_pkg::PH_TIME ||
             i_field_code == mrp_pkg::PH_NONCE || i_field_code == mrp_pkg::PH_IVLEN ||
             i_field_code == mrp_pkg::PH_TAGLEN || i_field_code == mrp_pkg::PH_SIGLEN ||
             i_field_code == mrp_pkg::PH_PAYLEN))
        else $error("word valid on a data field");

endmodule

bind message_record_parser_core mrp_checker u_mrp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_out.valid),
    .i_ready      (o_out.ready),
    .i_field_code (o_out.field_code),
    .i_word_value (o_out.word_value),
    .i_word_valid (o_out.word_valid),
    .i_record_end (o_out.record_end),
    .i_status     (o_out.status)
);
